@@ rtl/core/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg: chunked body decoder shared definitions
// Phase and result kind codes, parser state record, hex digit decode.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned SizeBitsDef   = 32;
  localparam int unsigned CountBits     = 32;
  localparam logic [31:0] MaxBodyReset  = 32'(5 * 1024 * 1024);
  localparam logic [7:0]  ByteCr        = 8'h0D;
  localparam logic [7:0]  ByteLf        = 8'h0A;
  localparam logic [1:0]  SkipAfterData = 2'd2;

  typedef enum logic [2:0] {
    PH_DIGITS = 3'd0,
    PH_TAIL   = 3'd1,
    PH_DATA   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_e;

  // parser control state (chunk size counter kept apart, its width is a parameter)
  typedef struct packed {
    phase_e               phase;
    logic                 digits_closed;
    logic                 saw_cr;
    logic [1:0]           skip_left;
    logic [CountBits-1:0] payload_count;
  } pstate_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ rtl/core/http_chunked_body_decoder_core.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: HTTP/1.1 chunked body decoder
// Strips chunk framing from a body byte stream, flags oversize input.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one raw body byte per transfer in s_axis_tdata;
//   s_axis_tuser set marks the first byte of a new body and clears the parser.
//   Master stream carries one result per producing byte: tuser is the kind
//   (payload byte, body complete, chunk size overflow, payload too large),
//   tdata the payload byte for payload results and zero otherwise. Size lines,
//   line ends and the two bytes after each chunk produce no transfer.
//   A result reaches the master side through the input register and then the
//   result register: the byte is held in the input register and the parser
//   step loads the result register from it. Throughput is one byte per cycle
//   while the master side does not stall, set by the single parser step between
//   those registers; the size counter and payload counter update in that same
//   step, so there is no loop across cycles.
//   When the master side stalls, the result register holds, the input register
//   fills behind it and then s_axis_tready drops; nothing is lost.
//   Reset empties both registers, puts the parser at the start of a size line
//   and loads max_body_bytes with 5 MiB. cfg_we_i/cfg_wdata_i write the limit;
//   write only while the block is idle.
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_body_bytes
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] body_start
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import hcbd_pkg::*;

  logic [31:0]          max_body_q;

  // input register
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_start_q;

  // parser state
  pstate_t              pstate_q, pstate_d;
  logic [SIZE_BITS-1:0] remaining_q, remaining_d;
  result_t              result;

  // result register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [7:0]           out_byte_q;

  logic                 advance;
  logic                 in_xfer;

  // parser step fires when the input register is full and the result slot frees
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyReset;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  hcbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .state_i         (pstate_q),
    .remaining_i     (remaining_q),
    .byte_value_i    (in_byte_q),
    .body_start_i    (in_start_q),
    .max_body_bytes_i(max_body_q),
    .state_o         (pstate_d),
    .remaining_o     (remaining_d),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pstate_q.phase         <= PH_DIGITS;
      pstate_q.digits_closed <= 1'b0;
      pstate_q.saw_cr        <= 1'b0;
      pstate_q.skip_left     <= 2'd0;
      pstate_q.payload_count <= '0;
      remaining_q            <= '0;
    end else if (advance) begin
      pstate_q    <= pstate_d;
      remaining_q <= remaining_d;
    end
  end

  // result register: loads on a producing step, drains on a master transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_kind_q <= result.kind;
      out_byte_q <= result.payload_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

@@ rtl/core/hcbd_parser.sv @@
// ----------------------------------------------------------------------------
// hcbd_parser: chunked body byte parser step
// Next parser state and optional result for one byte, combinational.
// ----------------------------------------------------------------------------
module hcbd_parser #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  hcbd_pkg::pstate_t       state_i,
  input  logic [SIZE_BITS-1:0]    remaining_i,
  input  logic [7:0]              byte_value_i,
  input  logic                    body_start_i,
  input  logic [31:0]             max_body_bytes_i,
  output hcbd_pkg::pstate_t       state_o,
  output logic [SIZE_BITS-1:0]    remaining_o,
  output hcbd_pkg::result_t       result_o
);
  import hcbd_pkg::*;

  pstate_t              cur;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] rem_dec;
  hex_t                 hex;
  logic                 is_cr;
  logic                 is_lf;

  always_comb begin
    // start flag clears the parser before the byte is handled
    if (body_start_i) begin
      cur.phase         = PH_DIGITS;
      cur.digits_closed = 1'b0;
      cur.saw_cr        = 1'b0;
      cur.skip_left     = 2'd0;
      cur.payload_count = '0;
      rem               = '0;
    end else begin
      cur = state_i;
      rem = remaining_i;
    end

    hex     = hex_decode(byte_value_i);
    is_cr   = (byte_value_i == ByteCr);
    is_lf   = (byte_value_i == ByteLf);
    rem_dec = rem - SIZE_BITS'(1);

    state_o               = cur;
    remaining_o           = rem;
    result_o.valid        = 1'b0;
    result_o.kind         = KIND_PAYLOAD;
    result_o.payload_byte = 8'd0;

    unique case (cur.phase)
      PH_DIGITS: begin
        if (is_lf && cur.saw_cr) begin
          state_o.saw_cr        = 1'b0;
          state_o.digits_closed = 1'b0;
          state_o.phase         = (rem == '0) ? PH_TAIL : PH_DATA;
        end else if (is_cr) begin
          state_o.saw_cr        = 1'b1;
          state_o.digits_closed = 1'b1;
        end else begin
          state_o.saw_cr = 1'b0;
          if (!cur.digits_closed && hex.valid) begin
            if (rem[SIZE_BITS-1 -: 4] != 4'd0) begin
              state_o.phase  = PH_ERROR;
              result_o.valid = 1'b1;
              result_o.kind  = KIND_OVERFLOW;
            end else begin
              remaining_o = {rem[SIZE_BITS-5:0], hex.value};
            end
          end else begin
            state_o.digits_closed = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        if (is_lf && cur.saw_cr) begin
          state_o.saw_cr = 1'b0;
          if (!cur.digits_closed) begin
            // empty line after the last chunk: body ends
            state_o.phase  = PH_DONE;
            result_o.valid = 1'b1;
            result_o.kind  = KIND_COMPLETE;
          end else begin
            state_o.digits_closed = 1'b0;
          end
        end else if (is_cr) begin
          if (cur.saw_cr) state_o.digits_closed = 1'b1;
          state_o.saw_cr = 1'b1;
        end else begin
          state_o.saw_cr        = 1'b0;
          state_o.digits_closed = 1'b1;
        end
      end
      PH_DATA: begin
        result_o.valid = 1'b1;
        if (cur.payload_count >= max_body_bytes_i) begin
          state_o.phase = PH_ERROR;
          result_o.kind = KIND_TOO_LARGE;
        end else begin
          state_o.payload_count = cur.payload_count + CountBits'(1);
          remaining_o           = rem_dec;
          result_o.payload_byte = byte_value_i;
          if (rem_dec == '0) begin
            state_o.phase     = PH_SKIP;
            state_o.skip_left = SkipAfterData;
          end
        end
      end
      PH_SKIP: begin
        if (cur.skip_left != 2'd0) state_o.skip_left = cur.skip_left - 2'd1;
        if (cur.skip_left <= 2'd1) begin
          state_o.phase         = PH_DIGITS;
          remaining_o           = '0;
          state_o.digits_closed = 1'b0;
          state_o.saw_cr        = 1'b0;
        end
      end
      default: begin
        // done and error: ignore bytes until the next start flag
      end
    endcase
  end

endmodule

@@ bench/tb_http_chunked_body_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core: self-checking bench for the chunk decoder
// Feeds chunked bodies, broken framing and noise into the byte stream, models
// the parser on every accepted byte and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_core;
  import hcbd_pkg::*;

  localparam int unsigned StallLimit = 2000;  // cycles with no transfer at all
  localparam int unsigned DirRows    = 29;

  // one decoded result: kind plus byte (zero unless payload)
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } decoded_t;

  // directed stimulus row; cfg rows write the limit instead of sending a byte
  typedef struct packed {
    bit         cfg;
    logic [31:0] limit;
    logic [7:0] b;
    logic       st;
    bit         typed;   // expectation written in the row below
    logic       has;
    kind_e      k;
    logic [7:0] pb;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = 32'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // typed expectation travels alongside the byte, sampled at the transfer
  bit          row_typed = 1'b0;
  logic        row_has   = 1'b0;
  kind_e       row_kind  = KIND_PAYLOAD;
  logic [7:0]  row_byte  = 8'd0;

  http_chunked_body_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  phase_e      dec_phase  = PH_DIGITS;
  logic [31:0] chunk_left = 32'd0;   // size being gathered, then bytes left
  logic        line_dirty = 1'b0;    // digits ended / trailer line not empty
  logic        prev_cr    = 1'b0;
  logic [1:0]  skip_cnt   = 2'd0;
  logic [31:0] paid_bytes = 32'd0;   // payload passed in this body
  logic [31:0] body_limit = MaxBodyReset;

  decoded_t    decoded_due[$];       // results owed by the block, oldest first

  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 84;
  int unsigned live_items  = 0;      // bytes the parser actually acted on
  int unsigned sent_items  = 0;      // every accepted input byte
  int unsigned fail_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned bodies_sent = 0;
  int unsigned limit_writes = 0;
  int unsigned kind_seen [4] = '{0, 0, 0, 0};

  // One parser step. live is low when the byte lands in done/error and is
  // dropped without effect.
  function automatic void decode_byte(input logic [7:0] b, input logic st,
                                      output logic has, output kind_e k,
                                      output logic [7:0] pb, output bit live);
    logic       is_hex;
    logic [3:0] nib;
    has = 1'b0;
    k   = KIND_PAYLOAD;
    pb  = 8'd0;
    if (st) begin
      dec_phase  = PH_DIGITS;
      chunk_left = 32'd0;
      line_dirty = 1'b0;
      prev_cr    = 1'b0;
      skip_cnt   = 2'd0;
      paid_bytes = 32'd0;
    end
    live = (dec_phase != PH_DONE) && (dec_phase != PH_ERROR);
    is_hex = 1'b1;
    nib    = 4'd0;
    if (b >= "0" && b <= "9") begin
      nib = b[3:0];
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      nib = 4'(b[2:0] + 3'd1) + 4'd8;  // 'a'/'A' low bits are 1 -> 10
    end else begin
      is_hex = 1'b0;
    end
    case (dec_phase)
      PH_DIGITS: begin
        if (b == ByteLf && prev_cr) begin
          prev_cr    = 1'b0;
          line_dirty = 1'b0;
          dec_phase  = (chunk_left == 32'd0) ? PH_TAIL : PH_DATA;
        end else if (b == ByteCr) begin
          prev_cr    = 1'b1;
          line_dirty = 1'b1;
        end else begin
          prev_cr = 1'b0;
          if (!line_dirty && is_hex) begin
            if (chunk_left[31:28] != 4'd0) begin
              dec_phase = PH_ERROR;
              has = 1'b1;
              k   = KIND_OVERFLOW;
            end else begin
              chunk_left = {chunk_left[27:0], nib};
            end
          end else begin
            line_dirty = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        // after the zero line: skip trailer lines, an empty line ends the body
        if (b == ByteLf && prev_cr) begin
          prev_cr = 1'b0;
          if (!line_dirty) begin
            dec_phase = PH_DONE;
            has = 1'b1;
            k   = KIND_COMPLETE;
          end else begin
            line_dirty = 1'b0;
          end
        end else if (b == ByteCr) begin
          if (prev_cr) line_dirty = 1'b1;
          prev_cr = 1'b1;
        end else begin
          prev_cr    = 1'b0;
          line_dirty = 1'b1;
        end
      end
      PH_DATA: begin
        if (paid_bytes >= body_limit) begin
          dec_phase = PH_ERROR;
          has = 1'b1;
          k   = KIND_TOO_LARGE;
        end else begin
          paid_bytes = paid_bytes + 32'd1;
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 32'd0) begin
            dec_phase = PH_SKIP;
            skip_cnt  = SkipAfterData;
          end
          has = 1'b1;
          pb  = b;
        end
      end
      PH_SKIP: begin
        // the two bytes after chunk data are dropped, whatever they hold
        if (skip_cnt != 2'd0) skip_cnt = skip_cnt - 2'd1;
        if (skip_cnt == 2'd0) begin
          dec_phase  = PH_DIGITS;
          chunk_left = 32'd0;
          line_dirty = 1'b0;
          prev_cr    = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: model every input transfer, check every result transfer.
  // Both sides in one process so an edge is always handled in the same order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic       has;
    kind_e      k;
    logic [7:0] pb;
    bit         live;
    decoded_t   want;
    decoded_t   due;
    if (s_axis_tvalid && s_axis_tready) begin
      decode_byte(s_axis_tdata, s_axis_tuser, has, k, pb, live);
      sent_items++;
      if (live) live_items++;
      if (row_typed) begin
        has = row_has;
        k   = row_kind;
        pb  = row_byte;
      end
      if (has) begin
        due = '{k, pb};
        decoded_due = {decoded_due, due};
      end
    end
    if (m_axis_tvalid && m_axis_tready) begin
      kind_seen[m_axis_tuser]++;
      if (decoded_due.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d byte %02h",
               m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = decoded_due.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.data) begin
          $error("payload_byte mismatch: expected %02h, actual %02h",
                 want.data, m_axis_tdata);
          fail_count++;
        end
      end
    end
    // watchdog: any transfer on either side counts as progress
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver stalls at random per the current idle mix
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Drop valid and wait for every owed result, then let in-flight bytes that
  // produce nothing clear the two pipeline stages.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    body_limit   = v;
    limit_writes++;
  endtask

  // One byte transfer. Returns at the edge that accepted it.
  task automatic send_byte(input logic [7:0] b, input logic st,
                           input bit typed = 1'b0, input logic has = 1'b0,
                           input kind_e k = KIND_PAYLOAD, input logic [7:0] pb = 8'd0);
    if ($urandom_range(399) == 0) begin
      settle();  // occasional full drain mid-body
    end else if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    row_typed     <= typed;
    row_has       <= has;
    row_kind      <= k;
    row_byte      <= pb;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // non-hex bytes, most right next to the hex ranges, to end the size digits
  function automatic logic [7:0] line_junk();
    case ($urandom_range(7))
      0: return 8'h3B;   // ;
      1: return 8'h20;   // space
      2: return 8'h67;   // g
      3: return 8'h47;   // G
      4: return 8'h2F;   // /
      5: return 8'h3A;   // :
      6: return 8'h40;   // @
      default: return 8'h60;
    endcase
  endfunction

  // One body: mostly well-formed framing with random content, some truncated
  // or corrupted, some with an oversize chunk count, a few of pure noise.
  task automatic drive_body();
    logic [7:0]  body_q[$];
    logic [31:0] sz;
    int unsigned shape;
    int unsigned cut;
    bit          started;
    logic        st_first;
    shape = $urandom_range(99);
    if (shape < 85) begin
      repeat ($urandom_range(3)) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) body_q = {body_q, 8'h30};
        started = 1'b0;
        for (int i = 7; i >= 0; i--) begin
          if (started || sz[4*i +: 4] != 4'd0) begin
            started = 1'b1;
            body_q = {body_q, hex_char(sz[4*i +: 4])};
          end
        end
        if ($urandom_range(3) == 0) begin
          body_q = {body_q, line_junk()};
          if ($urandom_range(1)) body_q = {body_q, hex_char(4'($urandom_range(15)))};
        end
        body_q = {body_q, ByteCr, ByteLf};
        repeat (sz) body_q = {body_q, 8'($urandom_range(255))};
        if ($urandom_range(9) == 0) begin
          body_q = {body_q, 8'($urandom_range(255))};
          body_q = {body_q, 8'($urandom_range(255))};
        end else begin
          body_q = {body_q, ByteCr, ByteLf};
        end
      end
      // last chunk: zero digits, or sometimes no digits at all
      if ($urandom_range(7) != 0) repeat ($urandom_range(1, 3)) body_q = {body_q, 8'h30};
      if ($urandom_range(3) == 0) body_q = {body_q, line_junk()};
      body_q = {body_q, ByteCr, ByteLf};
      repeat ($urandom_range(2)) begin
        // trailer line, now and then with a stray CR inside
        repeat ($urandom_range(1, 6)) begin
          body_q = {body_q,
                    (($urandom_range(4) == 0) ? ByteCr : 8'($urandom_range(65, 90)))};
        end
        body_q = {body_q, ByteCr, ByteLf};
      end
      body_q = {body_q, ByteCr, ByteLf};
      if (shape >= 75) begin
        if ($urandom_range(1)) begin
          cut = $urandom_range(1, body_q.size());
          while (body_q.size() > cut) void'(body_q.pop_back());
          repeat ($urandom_range(6)) body_q = {body_q, 8'($urandom_range(255))};
        end else begin
          body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom_range(255));
        end
      end
    end else if (shape < 95) begin
      // nine or more digits with a nonzero lead cannot fit the size counter
      body_q = {body_q, hex_char(4'($urandom_range(1, 15)))};
      repeat ($urandom_range(8, 10)) body_q = {body_q, hex_char(4'($urandom_range(15)))};
    end else begin
      repeat ($urandom_range(1, 12)) body_q = {body_q, 8'($urandom_range(255))};
    end
    st_first = ($urandom_range(19) != 0);
    foreach (body_q[i]) begin
      if (shape >= 95) send_byte(body_q[i], ($urandom_range(7) == 0));
      else send_byte(body_q[i], (i == 0) && st_first);
    end
    bodies_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Directed table: framing corners under the reset limit, then limit zero.
  // --------------------------------------------------------------------------
  dir_row_t dir_table [DirRows] = '{
    // no start flag yet: reset already leaves the parser on a size line
    '{1'b0, 32'd0, "2",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteCr, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    // CR without LF is just another line byte
    '{1'b0, 32'd0, "Q",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteCr, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteLf, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD,   8'h00},
    // payload extremes
    '{1'b0, 32'd0, 8'h00,  1'b0, 1'b1, 1'b1, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, 8'hFF,  1'b0, 1'b1, 1'b1, KIND_PAYLOAD,   8'hFF},
    // two bytes after the data are skipped even when they are not CR LF
    '{1'b0, 32'd0, "x",    1'b0, 1'b1, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "y",    1'b0, 1'b1, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteCr, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteLf, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteCr, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteLf, 1'b0, 1'b1, 1'b1, KIND_COMPLETE,  8'h00},
    // done: ignored until the next start
    '{1'b0, 32'd0, "Z",    1'b0, 1'b1, 1'b0, KIND_PAYLOAD,   8'h00},
    // 0x80000000 fits, the ninth digit overflows
    '{1'b0, 32'd0, "8",    1'b1, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "0",    1'b0, 1'b1, 1'b1, KIND_OVERFLOW,  8'h00},
    // limit zero: the first payload byte is already too much
    '{1'b1, 32'd0, 8'h00,  1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, "1",    1'b1, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteCr, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, ByteLf, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD,   8'h00},
    '{1'b0, 32'd0, 8'h5A,  1'b0, 1'b1, 1'b1, KIND_TOO_LARGE, 8'h00}
  };

  // random segments: idle mix and limit change between them
  int unsigned seg_tx [4]    = '{36, 84, 0, 0};
  int unsigned seg_rx [4]    = '{84, 36, 0, 0};
  int unsigned seg_items [4] = '{450, 450, 120, 480};

  initial begin
    logic [31:0] lim;
    int unsigned target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      if (dir_table[i].cfg) begin
        settle();
        write_limit(dir_table[i].limit);
      end else begin
        send_byte(dir_table[i].b, dir_table[i].st, dir_table[i].typed,
                  dir_table[i].has, dir_table[i].k, dir_table[i].pb);
      end
    end

    target = sent_items;
    for (int s = 0; s < 4; s++) begin
      settle();
      tx_idle_pct = seg_tx[s];
      rx_idle_pct = seg_rx[s];
      case (s)
        0: lim = 32'hFFFF_FFFF;                 // no limit in practice
        1: lim = $urandom_range(4, 48);         // bodies often run over
        2: lim = 32'd1;
        default: lim = MaxBodyReset;
      endcase
      write_limit(lim);
      target += seg_items[s];
      while (sent_items < target) drive_body();
    end

    settle();
    $display("Covered %0d bytes (%0d parsed) in %0d generated bodies, %0d limit writes,",
             sent_items, live_items, bodies_sent, limit_writes);
    $display("  results: %0d payload, %0d complete, %0d size overflow, %0d too large",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_COMPLETE],
             kind_seen[KIND_OVERFLOW], kind_seen[KIND_TOO_LARGE]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
